// File: design/sliding_window_byte_entropy_defines.svh
// Assertion macros used by the top-level design file.
`ifndef SLIDING_WINDOW_BYTE_ENTROPY_DEFINES_SVH
`define SLIDING_WINDOW_BYTE_ENTROPY_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication.
`define SWBE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swbe assertion failed");
// Next-cycle implication.
`define SWBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swbe assertion failed");
`else
`define SWBE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SWBE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/swbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package swbe_pkg;

  localparam int MAX_WINDOW_LOG2_DEF = 10;
  localparam int FRACTION_BITS_DEF   = 16;
  localparam int MANT_BITS           = 30;
  localparam int CFG_W               = 4;
  localparam logic [CFG_W-1:0] WLOG2_RESET = 4'd8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // take a beat, clear on start
    logic check;     // decide full, load divider, read ring
    logic div_step;  // one quotient bit
    logic h_rd;      // read histogram bin
    logic h_lk;      // look up the two table terms
    logic h_wr;      // write bin and running sum
    logic h_up;      // 1 = insert new byte, 0 = remove old byte
    logic emit;      // load the result register
  } swbe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic div_last;
    logic out_free;
  } swbe_stat_t;

  // c * log2(c) in fixed point with fb fraction bits, log2(0) = log2(1) = 0.
  // The fraction comes from repeated squaring of a Q30 mantissa.
  function automatic logic [63:0] xlogx(input int c, input int fb);
    int n;
    logic [63:0] m;
    logic [63:0] frac;
    n    = 0;
    frac = '0;
    if (c <= 1) begin
      return '0;
    end
    for (int i = 1; i < 31; i++) begin
      if ((c >> i) != 0) n = i;
    end
    m = 64'(c) << (MANT_BITS - n);
    for (int b = fb - 1; b >= 0; b--) begin
      m = (m * m) >> MANT_BITS;
      if (m >= (64'd2 << MANT_BITS)) begin
        m = m >> 1;
        frac = frac | (64'd1 << b);
      end
    end
    return 64'(c) * ((64'(n) << fb) | frac);
  endfunction

endpackage
`default_nettype wire

// File: design/swbe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module swbe_ctrl
  import swbe_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  swbe_stat_t stat,
  output swbe_cmd_t  cmd
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_CHECK  = 10'b0000000010,
    ST_DIV    = 10'b0000000100,
    ST_REM_RD = 10'b0000001000,
    ST_REM_LK = 10'b0000010000,
    ST_REM_WR = 10'b0000100000,
    ST_ADD_RD = 10'b0001000000,
    ST_ADD_LK = 10'b0010000000,
    ST_ADD_WR = 10'b0100000000,
    ST_EMIT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   emit_pend_r, emit_pend_nxt;

  // Input is taken only between beats.
  assign in_stall = (state_r != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    emit_pend_nxt = emit_pend_r;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check     = 1'b1;
        emit_pend_nxt = stat.full;
        state_nxt     = stat.full ? ST_DIV : ST_ADD_RD;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = ST_REM_RD;
      end
      ST_REM_RD: begin
        cmd.h_rd  = 1'b1;
        state_nxt = ST_REM_LK;
      end
      ST_REM_LK: begin
        cmd.h_lk  = 1'b1;
        state_nxt = ST_REM_WR;
      end
      ST_REM_WR: begin
        cmd.h_wr  = 1'b1;
        state_nxt = ST_ADD_RD;
      end
      ST_ADD_RD: begin
        cmd.h_rd  = 1'b1;
        cmd.h_up  = 1'b1;
        state_nxt = ST_ADD_LK;
      end
      ST_ADD_LK: begin
        cmd.h_lk  = 1'b1;
        cmd.h_up  = 1'b1;
        state_nxt = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        cmd.h_wr  = 1'b1;
        cmd.h_up  = 1'b1;
        state_nxt = emit_pend_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      emit_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      emit_pend_r <= emit_pend_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/swbe_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module swbe_dp
  import swbe_pkg::*;
#(
  parameter int MAX_WINDOW_LOG2 = MAX_WINDOW_LOG2_DEF,
  parameter int FRACTION_BITS   = FRACTION_BITS_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire  [7:0]       in_data_byte,
  input  wire              in_start_of_buffer,
  input  wire              cfg_we,
  input  wire  [CFG_W-1:0] cfg_wdata,
  input  wire              out_stall,
  output logic             out_valid,
  output logic [7:0]       out_entropy_level,
  input  swbe_cmd_t        cmd,
  output swbe_stat_t       stat
);

  localparam int KW        = $clog2(MAX_WINDOW_LOG2 + 1);
  localparam int CNT_W     = MAX_WINDOW_LOG2 + 1;
  localparam int PTR_W     = MAX_WINDOW_LOG2;
  localparam int SUM_W     = MAX_WINDOW_LOG2 + FRACTION_BITS + KW;
  localparam int NUM_W     = SUM_W + 8;
  localparam int RING_D    = 1 << MAX_WINDOW_LOG2;
  localparam int ROM_D     = RING_D + 1;

  // Window configuration.
  logic [SUM_W-1:0] full_r;
  logic [CNT_W-1:0] w_r;
  logic [KW-1:0]    k_sel;
  logic [CFG_W-1:0] k_src;

  // Window state.
  logic [PTR_W-1:0] ptr_r;
  logic [CNT_W-1:0] fill_r;
  logic [SUM_W-1:0] sum_r;
  logic [7:0]       byte_r;
  logic             clear;

  // Histogram and ring.
  logic [CNT_W-1:0] hist_mem [256];
  logic [255:0]     hvalid_r;
  logic [7:0]       ring_mem [RING_D];
  logic [7:0]       ring_q_r;
  logic [CNT_W-1:0] hist_q_r;
  logic             hval_q_r;
  logic [7:0]       haddr_r;
  logic [7:0]       h_addr;
  logic [CNT_W-1:0] c_cur;
  logic [CNT_W-1:0] c_nxt;
  logic [CNT_W-1:0] nc_r;

  // Term table.
  logic [SUM_W-1:0] rom_tab [ROM_D];
  logic [SUM_W-1:0] t_old_r;
  logic [SUM_W-1:0] t_new_r;
  logic [SUM_W-1:0] sum_less;

  // Divider.
  logic [NUM_W-1:0] rem_r;
  logic [NUM_W-1:0] dsh_r;
  logic [7:0]       q_r;
  logic [2:0]       step_r;
  logic [SUM_W-1:0] s_clamp;
  logic [SUM_W-1:0] diff;
  logic             ge;

  // Output register.
  logic             out_valid_r;
  logic [7:0]       out_level_r;

  logic [CNT_W-1:0] mask;
  logic [PTR_W-1:0] ptr_cur;

  // Constant table of c * log2(c).
  for (genvar g = 0; g < ROM_D; g++) begin : g_rom
    localparam logic [63:0] TERM = xlogx(g, FRACTION_BITS);
    assign rom_tab[g] = TERM[SUM_W-1:0];
  end

  // Effective window log2, clamped to 1..MAX.
  assign k_src = rst_n ? cfg_wdata : WLOG2_RESET;
  always_comb begin
    if (k_src == '0) begin
      k_sel = KW'(1);
    end else if ({1'b0, k_src} > 5'(MAX_WINDOW_LOG2)) begin
      k_sel = KW'(MAX_WINDOW_LOG2);
    end else begin
      k_sel = KW'(k_src);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      w_r    <= CNT_W'(1) << k_sel;
      full_r <= SUM_W'(k_sel) << (32'(k_sel) + FRACTION_BITS);
    end
  end

  assign clear   = !rst_n || cfg_we || (cmd.accept && in_start_of_buffer);
  assign mask    = w_r - CNT_W'(1);
  assign ptr_cur = ptr_r & mask[PTR_W-1:0];

  assign stat.full     = (fill_r >= w_r);
  assign stat.div_last = (step_r == 3'd7);
  assign stat.out_free = !out_valid_r || !out_stall;

  // Beat capture.
  always_ff @(posedge clk) begin
    if (cmd.accept) byte_r <= in_data_byte;
  end

  // Histogram address and the bin's new count.
  assign h_addr = cmd.h_up ? byte_r : ring_q_r;
  assign c_cur  = hval_q_r ? hist_q_r : '0;
  always_comb begin
    if (cmd.h_up) begin
      c_nxt = c_cur + CNT_W'(1);
    end else begin
      c_nxt = (c_cur != '0) ? c_cur - CNT_W'(1) : '0;
    end
  end
  assign sum_less = (sum_r >= t_old_r) ? sum_r - t_old_r : '0;

  // Window control registers.
  always_ff @(posedge clk) begin
    if (clear) begin
      ptr_r    <= '0;
      fill_r   <= '0;
      sum_r    <= '0;
      hvalid_r <= '0;
    end else begin
      if (cmd.check && !stat.full) fill_r <= fill_r + CNT_W'(1);
      if (cmd.h_wr) begin
        sum_r             <= sum_less + t_new_r;
        hvalid_r[haddr_r] <= 1'b1;
      end
      if (cmd.h_wr && cmd.h_up) ptr_r <= (ptr_cur + PTR_W'(1)) & mask[PTR_W-1:0];
    end
  end

  // Histogram memory.
  always_ff @(posedge clk) begin
    if (cmd.h_wr) hist_mem[haddr_r] <= nc_r;
    if (cmd.h_rd) begin
      hist_q_r <= hist_mem[h_addr];
      hval_q_r <= hvalid_r[h_addr];
      haddr_r  <= h_addr;
    end
  end

  // Ring memory.
  always_ff @(posedge clk) begin
    if (cmd.h_wr && cmd.h_up) ring_mem[ptr_cur] <= byte_r;
    if (cmd.check) ring_q_r <= ring_mem[ptr_cur];
  end

  // Table lookups for the old and new count.
  always_ff @(posedge clk) begin
    if (cmd.h_lk) begin
      t_old_r <= rom_tab[c_cur];
      t_new_r <= rom_tab[c_nxt];
      nc_r    <= c_nxt;
    end
  end

  // Restoring divider for floor(255 * (full - S) / full).
  assign s_clamp = (sum_r > full_r) ? full_r : sum_r;
  assign diff    = full_r - s_clamp;
  assign ge      = (rem_r >= dsh_r);
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      rem_r  <= (NUM_W'(diff) << 8) - NUM_W'(diff);
      dsh_r  <= NUM_W'(full_r) << 7;
      q_r    <= '0;
      step_r <= '0;
    end else if (cmd.div_step) begin
      if (ge) rem_r <= rem_r - dsh_r;
      q_r    <= {q_r[6:0], ge};
      dsh_r  <= dsh_r >> 1;
      step_r <= step_r + 3'd1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.emit) out_level_r <= q_r;
  end

  assign out_valid         = out_valid_r;
  assign out_entropy_level = out_level_r;

endmodule
`default_nettype wire

// File: design/sliding_window_byte_entropy.sv
// While the window fills, each beat's histogram bin is read, looked up and written
// back with no result; once full, the bit-serial divider runs first, then the old
// and new bytes' bins are each updated and the result is loaded once the output is free.
// Beats are taken one at a time: in_stall holds off the next until that work is done.
// Reset (rst_n low, synchronous) clears histogram, ring pointer, fill count and
// sum and sets window_log2 to 8; the ring contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_byte_entropy_defines.svh"
module sliding_window_byte_entropy
  import swbe_pkg::*;
#(
  parameter int MAX_WINDOW_LOG2 = MAX_WINDOW_LOG2_DEF,
  parameter int FRACTION_BITS   = FRACTION_BITS_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_stall,
  input  wire  [7:0]       in_data_byte,
  input  wire              in_start_of_buffer,
  output logic             out_valid,
  input  wire              out_stall,
  output logic [7:0]       out_entropy_level,
  input  wire              cfg_we,
  input  wire  [CFG_W-1:0] cfg_wdata
);

  swbe_cmd_t  cmd;
  swbe_stat_t stat;

  // Sequencer.
  swbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Histogram, ring, table and divider.
  swbe_dp #(
    .MAX_WINDOW_LOG2 (MAX_WINDOW_LOG2),
    .FRACTION_BITS   (FRACTION_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_data_byte       (in_data_byte),
    .in_start_of_buffer (in_start_of_buffer),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_entropy_level  (out_entropy_level),
    .cmd                (cmd),
    .stat               (stat)
  );

  // A taken beat holds off the next one while it is processed.
  `SWBE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  // A new result only comes from the controller's load command.
  `SWBE_ASSERT_NOW(a_result_from_emit, clk, rst_n, $rose(out_valid), $past(cmd.emit))
  // Results are loaded only while no beat is being taken.
  `SWBE_ASSERT_NOW(a_emit_not_idle, clk, rst_n, cmd.emit, in_stall)

endmodule
`default_nettype wire
